// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros
// assertion helpers for the cache checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication outside reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lfu_pkg.sv =====
// ---------------------------------------------------------------------------
// lfu_pkg
// shared widths, constants and control types for the lfu cache table
// ---------------------------------------------------------------------------
package lfu_pkg;

  localparam int Capacity = 16;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int UseW     = 16;
  localparam int KeyW     = 32;
  localparam int DataW    = 32;

  localparam logic [UseW-1:0] UseMax = {UseW{1'b1}};

  localparam logic FuncGet = 1'b0;
  localparam logic FuncPut = 1'b1;

  // one entry's metadata as held in the memory
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] data;
    logic [UseW-1:0]  uses;
    logic [IdxW-1:0]  rank;
  } entry_t;

  // write port request into the entry memory
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  addr;
    entry_t           wdata;
  } mem_wr_t;

endpackage

// ===== sv/lfu_entry_ram.sv =====
// ---------------------------------------------------------------------------
// lfu_entry_ram
// synchronous memory with one write port and one read port, one entry per row
// ---------------------------------------------------------------------------
module lfu_entry_ram (
  input  logic              clk,
  input  lfu_pkg::mem_wr_t  wr,
  input  logic [lfu_pkg::IdxW-1:0] raddr,
  output lfu_pkg::entry_t   rdata
);
  import lfu_pkg::*;

  entry_t mem [Capacity];

  // write then registered read
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lfu_ctrl.sv =====
// ---------------------------------------------------------------------------
// lfu_ctrl
// sequencer: scans the entry memory for key and victim, then updates ranks
// ---------------------------------------------------------------------------
module lfu_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lfu_pkg::CntW-1:0]   cap_in_use,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       func,
  input  logic [lfu_pkg::KeyW-1:0]   key,
  input  logic [lfu_pkg::DataW-1:0]  value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       hit,
  output logic [lfu_pkg::DataW-1:0]  read_value,
  output logic                       evicted,
  output logic [lfu_pkg::KeyW-1:0]   evicted_key,
  output lfu_pkg::mem_wr_t           wr,
  output logic [lfu_pkg::IdxW-1:0]   raddr,
  input  lfu_pkg::entry_t            rdata
);
  import lfu_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StDecide = 3'd2;
  localparam logic [2:0] StFix   = 3'd3;
  localparam logic [2:0] StWrite = 3'd4;

  logic [2:0] state;
  logic [Capacity-1:0] valid;
  logic [CntW-1:0] fill;

  // captured request
  logic             op;
  logic [KeyW-1:0]  op_key;
  logic [DataW-1:0] op_val;

  // scan pointers: issue address and the address whose data is arriving
  logic [CntW-1:0]  iss;
  logic             rd_pend;
  logic [IdxW-1:0]  rd_addr;

  // scan results
  logic             found;
  logic [IdxW-1:0]  found_idx;
  entry_t           found_ent;
  logic             vic_ok;
  logic [IdxW-1:0]  vic_idx;
  entry_t           vic_ent;
  logic             free_ok;
  logic [IdxW-1:0]  free_idx;

  // rank fixup decision
  logic             gap_on;
  logic [IdxW-1:0]  gap_rank;
  logic [IdxW-1:0]  tgt_idx;
  entry_t           tgt_ent;
  logic             tgt_we;
  logic             drop_vic;

  logic [CntW-1:0]  eff_cap;

  always_comb begin
    eff_cap = cap_in_use;
    if (cap_in_use == '0) eff_cap = CntW'(1);
    if (cap_in_use > CntW'(Capacity)) eff_cap = CntW'(Capacity);
  end

  assign in_ready = (state == StIdle) && !out_valid;
  assign raddr = iss[IdxW-1:0];

  // fixup pass writes the read row back with its rank adjusted
  entry_t fix_ent;
  always_comb begin
    fix_ent = rdata;
    if (gap_on && rdata.rank > gap_rank) begin
      fix_ent.rank = rdata.rank - IdxW'(1);
    end
  end

  always_comb begin
    wr = '0;
    if (state == StFix && rd_pend && valid[rd_addr] && rd_addr != tgt_idx) begin
      wr.we = 1'b1;
      wr.addr = rd_addr;
      wr.wdata = fix_ent;
    end else if (state == StWrite && tgt_we) begin
      wr.we = 1'b1;
      wr.addr = tgt_idx;
      wr.wdata = tgt_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      valid <= '0;
      fill <= '0;
      out_valid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        StIdle: begin
          if (in_valid && in_ready) begin
            op <= func;
            op_key <= key;
            op_val <= value;
            iss <= '0;
            rd_pend <= 1'b0;
            found <= 1'b0;
            vic_ok <= 1'b0;
            free_ok <= 1'b0;
            state <= StScan;
          end
        end
        StScan: begin
          // one row issued and one row compared per cycle
          if (iss < CntW'(Capacity)) begin
            rd_pend <= 1'b1;
            rd_addr <= iss[IdxW-1:0];
            iss <= iss + CntW'(1);
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            if (valid[rd_addr]) begin
              if (!found && rdata.key == op_key) begin
                found <= 1'b1;
                found_idx <= rd_addr;
                found_ent <= rdata;
              end
              if (!vic_ok || rdata.uses < vic_ent.uses ||
                  (rdata.uses == vic_ent.uses && rdata.rank < vic_ent.rank)) begin
                vic_ok <= 1'b1;
                vic_idx <= rd_addr;
                vic_ent <= rdata;
              end
            end else if (!free_ok) begin
              free_ok <= 1'b1;
              free_idx <= rd_addr;
            end
          end
          if (!rd_pend && iss == CntW'(Capacity)) state <= StDecide;
        end
        StDecide: begin
          gap_on <= 1'b0;
          tgt_we <= 1'b0;
          drop_vic <= 1'b0;
          hit <= found;
          read_value <= '0;
          evicted <= 1'b0;
          evicted_key <= '0;
          if (found) begin
            gap_on <= 1'b1;
            gap_rank <= found_ent.rank;
            tgt_we <= 1'b1;
            tgt_idx <= found_idx;
            tgt_ent <= found_ent;
            tgt_ent.rank <= fill[IdxW-1:0] - IdxW'(1);
            if (found_ent.uses != UseMax) tgt_ent.uses <= found_ent.uses + UseW'(1);
            if (op == FuncPut) tgt_ent.data <= op_val;
            else read_value <= found_ent.data;
          end else if (op == FuncPut) begin
            tgt_we <= 1'b1;
            tgt_ent.key <= op_key;
            tgt_ent.data <= op_val;
            tgt_ent.uses <= UseW'(1);
            if (fill >= eff_cap && vic_ok) begin
              // evict victim and reuse its row
              evicted <= 1'b1;
              evicted_key <= vic_ent.key;
              gap_on <= 1'b1;
              gap_rank <= vic_ent.rank;
              drop_vic <= 1'b1;
              tgt_idx <= vic_idx;
              tgt_ent.rank <= fill[IdxW-1:0] - IdxW'(1);
            end else if (free_ok) begin
              tgt_idx <= free_idx;
              tgt_ent.rank <= fill[IdxW-1:0];
            end else begin
              tgt_we <= 1'b0;
            end
          end
          iss <= '0;
          rd_pend <= 1'b0;
          state <= StFix;
        end
        StFix: begin
          // when a rank gap is open, a second sweep closes it on every other valid row
          if (!gap_on) begin
            state <= StWrite;
          end else begin
            if (iss < CntW'(Capacity)) begin
              rd_pend <= 1'b1;
              rd_addr <= iss[IdxW-1:0];
              iss <= iss + CntW'(1);
            end else begin
              rd_pend <= 1'b0;
            end
            if (!rd_pend && iss == CntW'(Capacity)) state <= StWrite;
          end
        end
        StWrite: begin
          if (tgt_we && !drop_vic && !found) begin
            valid[tgt_idx] <= 1'b1;
            fill <= fill + CntW'(1);
          end
          out_valid <= 1'b1;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule

// ===== sv/lfu_cache_table.sv =====
// ---------------------------------------------------------------------------
// lfu_cache_table
// lfu key-value cache, ties broken by least recent use
// ---------------------------------------------------------------------------
// usage:
//   requests enter on in_valid/in_ready with func (0 get, 1 put), key, value.
//   one result per request leaves on out_valid/out_ready with hit,
//   read_value, evicted and evicted_key.
//   cap_in_use is written on cfg_valid/cfg_ready; the user must do so only
//   while the block is idle, and the block itself does not enforce it;
//   0 acts as 1, values above 16 act as 16.
// sequence: a hit or an eviction takes a key and victim scan of one memory
//   row per cycle, then a rank fixup sweep; a get miss or a put into a free
//   row takes the scan alone. One request at a time: the next request is
//   taken only after the previous result has left on out_valid/out_ready.
// reset: rst clears the valid bits and fill count, cap_in_use returns to 16;
//   no clearing pass is needed.
// stall: a held result blocks the next request until out_ready takes it.
// ---------------------------------------------------------------------------
module lfu_cache_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [31:0] read_value,
  output logic        evicted,
  output logic [31:0] evicted_key
);
  import lfu_pkg::*;

  logic [CntW-1:0] cap_in_use;
  mem_wr_t         wr;
  logic [IdxW-1:0] raddr;
  entry_t          rdata;

  assign cfg_ready = 1'b1;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_in_use <= CntW'(Capacity);
    end else if (cfg_valid && cfg_ready) begin
      cap_in_use <= cfg_data;
    end
  end

  lfu_entry_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  lfu_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cap_in_use  (cap_in_use),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key),
    .wr          (wr),
    .raddr       (raddr),
    .rdata       (rdata)
  );

endmodule

// ===== sv/lfu_checker.sv =====
// ---------------------------------------------------------------------------
// lfu_checker
// port level checks on the cache table
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [31:0] read_value,
  input logic        evicted,
  input logic [31:0] evicted_key
);

  // a request is never taken while a result is still pending
  `CHK_IMPLY(a_no_overlap, clk, rst, out_valid, !in_ready, "request taken with result pending")
  // a request is never answered in the next cycle
  `CHK_NEXT(a_no_instant, clk, rst, in_valid && in_ready, !out_valid, "result too early")
  // a hit never reports an eviction
  `CHK_IMPLY(a_hit_no_evict, clk, rst, out_valid && hit, !evicted, "eviction on hit")
  // without eviction the evicted key reads zero
  `CHK_IMPLY(a_evkey_zero, clk, rst, out_valid && !evicted, evicted_key == 32'd0,
             "stray evicted key")
  // a result stalled by the receiver stays valid and its read_value holds
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(read_value),
            "stalled result changed")

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .hit         (hit),
  .read_value  (read_value),
  .evicted     (evicted),
  .evicted_key (evicted_key)
);

// ===== test/lfu_cache_table_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfu_cache_table_checker
// watches the config, request and result channels, keeps its own copy of
// the cache table, predicts each result and compares it field by field
// ---------------------------------------------------------------------------
module lfu_cache_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [31:0] key,
  input  logic [31:0] value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        hit,
  input  logic [31:0] read_value,
  input  logic        evicted,
  input  logic [31:0] evicted_key,
  output int          fail_count,
  output int          pending
);
  import lfu_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lookup_t;

  // shadow table
  logic             sh_valid [Capacity];
  logic [KeyW-1:0]  sh_key   [Capacity];
  logic [DataW-1:0] sh_data  [Capacity];
  logic [UseW-1:0]  sh_uses  [Capacity];
  int               sh_rank  [Capacity];
  int               sh_fill;
  logic [4:0]       sh_cap;
  lookup_t          lookups_due [$];

  assign pending = lookups_due.size();

  // drop rank r out of the recency order
  function automatic void close_gap(int r);
    for (int j = 0; j < Capacity; j++)
      if (sh_valid[j] && sh_rank[j] > r) sh_rank[j]--;
  endfunction

  function automatic lookup_t cache_access(logic f, logic [31:0] k, logic [31:0] v);
    lookup_t res;
    int idx, vic, slot, cap;
    res = '0;
    idx = -1;
    vic = -1;
    slot = -1;
    cap = (sh_cap == 0) ? 1 : ((sh_cap > Capacity) ? Capacity : int'(sh_cap));
    for (int j = 0; j < Capacity; j++)
      if (idx < 0 && sh_valid[j] && sh_key[j] == k) idx = j;
    if (idx >= 0) begin
      res.hit = 1'b1;
      if (f == FuncGet) res.read_value = sh_data[idx];
      else sh_data[idx] = v;
      close_gap(sh_rank[idx]);
      sh_rank[idx] = sh_fill - 1;
      if (sh_uses[idx] != UseMax) sh_uses[idx]++;
    end else if (f == FuncPut) begin
      if (sh_fill >= cap) begin
        for (int j = 0; j < Capacity; j++) begin
          if (!sh_valid[j]) continue;
          if (vic < 0 || sh_uses[j] < sh_uses[vic] ||
              (sh_uses[j] == sh_uses[vic] && sh_rank[j] < sh_rank[vic])) vic = j;
        end
        if (vic >= 0) begin
          res.evicted = 1'b1;
          res.evicted_key = sh_key[vic];
          close_gap(sh_rank[vic]);
          sh_valid[vic] = 1'b0;
          sh_fill--;
        end
      end
      for (int j = 0; j < Capacity; j++)
        if (slot < 0 && !sh_valid[j]) slot = j;
      if (slot >= 0) begin
        sh_valid[slot] = 1'b1;
        sh_key[slot] = k;
        sh_data[slot] = v;
        sh_uses[slot] = UseW'(1);
        sh_rank[slot] = sh_fill;
        sh_fill++;
      end
    end
    return res;
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      for (int j = 0; j < Capacity; j++) sh_valid[j] = 1'b0;
      sh_fill = 0;
      sh_cap = 5'd16;
      fail_count = 0;
      lookups_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) sh_cap = cfg_data;
      if (out_valid && out_ready) begin
        if (lookups_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result at %0t", $time);
        end else begin
          want = lookups_due.pop_front();
          if (want.hit !== hit || want.read_value !== read_value ||
              want.evicted !== evicted || want.evicted_key !== evicted_key) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch at %0t: expected hit %0b data %h ev %0b evkey %h,",
                        " got %0b %h %0b %h"},
                       $time, want.hit, want.read_value, want.evicted, want.evicted_key,
                       hit, read_value, evicted, evicted_key);
          end
        end
      end
      if (in_valid && in_ready) lookups_due.push_back(cache_access(func, key, value));
    end
  end
endmodule

// ===== test/lfu_cache_table_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfu_cache_table_test
// drives directed and random get/put traffic through several capacities
// with random idling on both sides; the checker predicts and compares
// ---------------------------------------------------------------------------
module lfu_cache_table_test;
  import lfu_pkg::*;

  localparam int WatchdogLimit = 4000;

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [4:0]  cfg_data;
  logic        in_valid, in_ready, func;
  logic [31:0] key, value;
  logic        out_valid, out_ready, hit, evicted;
  logic [31:0] read_value, evicted_key;
  int          fail_count, pending;
  int          idle_cycles;
  bit          calm;

  lfu_cache_table DUT (.*);
  lfu_cache_table_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // watchdog on cycles with no accepted transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("lfu_cache_table test failed");
      $finish;
    end
  end

  // result side stalls in bursts
  initial begin
    int burst;
    out_ready = 0;
    @(posedge clk iff !rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 16);
        out_ready <= 0;
        repeat (burst) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  // in_valid is low on entry; it drops after the accept and is still low when the task returns
  task automatic send_request(logic f, logic [31:0] k, logic [31:0] v);
    if (!calm && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    key <= k;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] c);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // keys from a small pool so hits and evictions are common
  function automatic logic [31:0] pool_key(int span);
    if ($urandom_range(0, 19) == 0) return $urandom;
    return 32'hFFFF_FF00 ^ $urandom_range(0, span);
  endfunction

  initial begin
    logic [4:0] caps [6] = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd4, 5'd9};
    calm = 0;
    rst = 1;
    cfg_valid = 0; cfg_data = 0;
    in_valid = 0; func = FuncGet; key = 0; value = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, miss, hit, overwrite, fill and evict
    send_request(FuncGet, 32'h0, 32'h0);
    send_request(FuncPut, 32'h0, 32'hFFFF_FFFF);
    send_request(FuncPut, 32'hFFFF_FFFF, 32'h0);
    send_request(FuncGet, 32'h0, 32'h1234_5678);
    send_request(FuncPut, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    send_request(FuncGet, 32'hFFFF_FFFF, 32'h0);
    for (int i = 0; i < 17; i++) send_request(FuncPut, 32'h100 + i, ~i);
    send_request(FuncGet, 32'h0, 32'h0);
    // capacity lowered below the fill
    write_capacity(5'd2);
    send_request(FuncPut, 32'h5555_AAAA, 32'h1);
    send_request(FuncPut, 32'hAAAA_5555, 32'h2);

    // random phases over several capacities
    for (int ph = 0; ph < 6; ph++) begin
      int span;
      write_capacity(caps[ph]);
      span = $urandom_range(2, 40);
      if (ph == 5) calm = 1;
      for (int i = 0; i < 330; i++)
        send_request(1'($urandom_range(0, 1)), pool_key(span), $urandom);
    end
    // repeated hits on one key raise its count above the newcomers
    write_capacity(5'd3);
    send_request(FuncPut, 32'hC0DE, 32'h7);
    for (int i = 0; i < 20; i++) send_request(FuncGet, 32'hC0DE, 0);
    send_request(FuncPut, 32'h1, 1);
    send_request(FuncPut, 32'h2, 2);
    send_request(FuncPut, 32'h3, 3);

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("lfu_cache_table test passed");
    else $display("lfu_cache_table test failed");
    $finish;
  end
endmodule
